[design/ssa_pkg.sv]
// shared types and constants for the searchable stack with average
`timescale 1ns / 1ps

package ssa_pkg;

   // field widths of the request and response items
   localparam int TYPE_W   = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_PUSH   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_POP    = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_SEARCH = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_SEARCH,
      S_AVG_GO,
      S_AVG,
      S_OUT
   } ssa_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic pop;
      logic srch_step;
      logic div_start;
      logic load_rsp;
   } ssa_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic srch_done;
      logic div_done;
      logic out_free;
   } ssa_stat_type;

endpackage

[design/searchable_stack_with_average_unit.sv]
// top level of the searchable stack with running average
`timescale 1ns / 1ps

// a bounded lifo of DEPTH signed 32-bit values; each item is a push, a pop or a
// search (code 3 is taken and answered with ok and no change), and each gives
// exactly one response item carrying a status, the popped value, the distance
// from the top of the nearest match, the entry count after the item and the
// average of the held values truncated toward zero (0 when empty). items are
// handled one at a time: req_stall is low only while the unit is idle, and a
// response held in the output register does not keep the next item out. a
// push, a pop on an empty stack or an unused code goes straight to the average,
// computed by the bit-serial divider, one quotient bit a cycle, and then to the
// output register. a pop that removes an entry first reads the stack top in a
// state of its own. a search first walks the stack: the single-port stack memory
// delivers one entry a cycle, top first, and the walk stops at the first match.
// the unit is idle again in the cycle after the response is loaded; a response
// not yet taken from the output register holds the following response back
// until it goes. the stack memory needs no clearing: only entries below the
// fill count are ever read
module searchable_stack_with_average_unit #(
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ssa_pkg::TYPE_W-1:0]           req_type,
   input  logic signed [ssa_pkg::DATA_W-1:0]    req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ssa_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [ssa_pkg::DATA_W-1:0]    rsp_data,
   output logic [ssa_pkg::POS_W-1:0]            rsp_match_pos,
   output logic [ssa_pkg::COUNT_W-1:0]          rsp_entry_count,
   output logic signed [ssa_pkg::DATA_W-1:0]    rsp_average
);

   // count holds 0 to DEPTH, address 0 to DEPTH-1
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // sum of DEPTH 32-bit values with room for the sign
   localparam int SUM_W = 33 + CNT_W;

   ssa_pkg::ssa_cmd_type  cmd;
   ssa_pkg::ssa_stat_type stat;

   ssa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ssa_datapath #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W),
      .AW    (AW),
      .SUM_W (SUM_W)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_type        (req_type),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_data        (rsp_data),
      .rsp_match_pos   (rsp_match_pos),
      .rsp_entry_count (rsp_entry_count),
      .rsp_average     (rsp_average)
   );

endmodule

[design/ssa_div.sv]
// bit-serial signed divider for the running average, one quotient bit a cycle
`timescale 1ns / 1ps

module ssa_div #(
   parameter int SUM_W = 40,
   parameter int CNT_W = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [SUM_W-1:0]     dividend,
   input  logic        [CNT_W-1:0]     divisor,
   output logic                        done,
   output logic [ssa_pkg::DATA_W-1:0]  quotient
);

   localparam int SC_W = $clog2(SUM_W + 1);
   localparam logic [SC_W-1:0] LAST_STEP = SC_W'(SUM_W - 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [SC_W-1:0]             step_ff, step_in;
   logic [SUM_W-1:0]            acc_ff, acc_in;
   logic [CNT_W-1:0]            rem_ff, rem_in;
   logic [CNT_W-1:0]            div_ff, div_in;
   logic                        neg_ff, neg_in;
   logic                        zero_ff, zero_in;
   logic [ssa_pkg::DATA_W-1:0]  quot_ff, quot_in;

   logic [CNT_W:0]              rem_sh;
   logic [CNT_W:0]              rem_sub;
   logic                        ge;
   logic [SUM_W-1:0]            acc_next;
   logic [SUM_W-1:0]            mag;
   logic [ssa_pkg::DATA_W-1:0]  q_mag;

   always_comb begin
      mag      = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem_sh   = {rem_ff, acc_ff[SUM_W-1]};
      ge       = rem_sh >= {1'b0, div_ff};
      rem_sub  = rem_sh - {1'b0, div_ff};
      acc_next = {acc_ff[SUM_W-2:0], ge};
      q_mag    = acc_next[ssa_pkg::DATA_W-1:0];

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      quot_in = quot_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         acc_in  = mag;
         rem_in  = '0;
         div_in  = divisor;
         neg_in  = dividend[SUM_W-1];
         zero_in = divisor == '0;
      end else if (busy_ff) begin
         acc_in  = acc_next;
         rem_in  = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         step_in = step_ff + SC_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            // truncation toward zero: divide magnitudes, then restore the sign
            if (zero_ff) begin
               quot_in = '0;
            end else if (neg_ff) begin
               quot_in = -q_mag;
            end else begin
               quot_in = q_mag;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule

[design/ssa_datapath.sv]
// stack memory, fill count, running sum, search pipeline and response register
`timescale 1ns / 1ps

module ssa_datapath #(
   parameter int DEPTH = 64,
   parameter int CNT_W = 7,
   parameter int AW    = 6,
   parameter int SUM_W = 40
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ssa_pkg::ssa_cmd_type                 cmd,
   output ssa_pkg::ssa_stat_type                stat,
   input  logic [ssa_pkg::TYPE_W-1:0]           req_type,
   input  logic signed [ssa_pkg::DATA_W-1:0]    req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ssa_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [ssa_pkg::DATA_W-1:0]    rsp_data,
   output logic [ssa_pkg::POS_W-1:0]            rsp_match_pos,
   output logic [ssa_pkg::COUNT_W-1:0]          rsp_entry_count,
   output logic signed [ssa_pkg::DATA_W-1:0]    rsp_average
);

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   logic [ssa_pkg::DATA_W-1:0]     mem [DEPTH];
   logic [ssa_pkg::DATA_W-1:0]     rd_data_ff;

   logic [CNT_W-1:0]               fill_ff, fill_in;
   logic signed [SUM_W-1:0]        sum_ff, sum_in;
   logic [ssa_pkg::DATA_W-1:0]     key_ff, key_in;
   logic [CNT_W-1:0]               k_ff, k_in;
   logic                           cmp_vld_ff, cmp_vld_in;
   logic [CNT_W-1:0]               cmp_k_ff, cmp_k_in;
   logic [ssa_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [ssa_pkg::DATA_W-1:0]     data_ff, data_in;
   logic [CNT_W-1:0]               pos_ff, pos_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ssa_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ssa_pkg::DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [ssa_pkg::POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [ssa_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [ssa_pkg::DATA_W-1:0]     rsp_avg_ff, rsp_avg_in;

   logic                           full;
   logic                           empty;
   logic                           wr_en;
   logic                           rd_en;
   logic [CNT_W-1:0]               k_sel;
   logic [CNT_W-1:0]               rd_ptr;
   logic                           srch_issue;
   logic                           hit;
   logic                           div_done;
   logic [ssa_pkg::DATA_W-1:0]     quotient;
   logic [CNT_W+ssa_pkg::POS_W-1:0]   pos_ext;
   logic [CNT_W+ssa_pkg::COUNT_W-1:0] cnt_ext;

   assign full  = fill_ff == FULL_COUNT;
   assign empty = fill_ff == '0;

   // push writes at the fill point, pop and search read below it
   assign wr_en      = cmd.accept && req_type == ssa_pkg::REQ_PUSH && !full;
   assign srch_issue = cmd.srch_step && (k_ff < fill_ff);
   assign rd_en      = (cmd.accept && req_type == ssa_pkg::REQ_POP && !empty) || srch_issue;
   assign k_sel      = cmd.accept ? '0 : k_ff;
   assign rd_ptr     = fill_ff - CNT_W'(1) - k_sel;
   assign hit        = cmd.srch_step && cmp_vld_ff && (rd_data_ff == key_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[fill_ff[AW-1:0]] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr[AW-1:0]];
      end
   end

   ssa_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign pos_ext = {{ssa_pkg::POS_W{1'b0}}, pos_ff};
   assign cnt_ext = {{ssa_pkg::COUNT_W{1'b0}}, fill_ff};

   always_comb begin
      fill_in    = fill_ff;
      sum_in     = sum_ff;
      key_in     = key_ff;
      k_in       = k_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_k_in   = cmp_k_ff;
      status_in  = status_ff;
      data_in    = data_ff;
      pos_in     = pos_ff;

      if (cmd.accept) begin
         key_in     = req_value;
         k_in       = '0;
         cmp_vld_in = 1'b0;
         data_in    = '0;
         pos_in     = '0;
         status_in  = ssa_pkg::STAT_OK;
         case (req_type)
            ssa_pkg::REQ_PUSH: begin
               if (full) begin
                  status_in = ssa_pkg::STAT_FULL;
               end else begin
                  fill_in = fill_ff + CNT_W'(1);
                  sum_in  = sum_ff + SUM_W'(req_value);
               end
            end
            ssa_pkg::REQ_POP: begin
               if (empty) begin
                  status_in = ssa_pkg::STAT_EMPTY;
               end
            end
            ssa_pkg::REQ_SEARCH: begin
               status_in = ssa_pkg::STAT_NOT_FOUND;
            end
            default: begin
               status_in = ssa_pkg::STAT_OK;
            end
         endcase
      end else if (cmd.pop) begin
         fill_in = fill_ff - CNT_W'(1);
         sum_in  = sum_ff - SUM_W'($signed(rd_data_ff));
         data_in = rd_data_ff;
      end else if (cmd.srch_step) begin
         // read one entry a cycle, compare it the cycle after
         cmp_vld_in = srch_issue;
         cmp_k_in   = k_ff;
         if (srch_issue) begin
            k_in = k_ff + CNT_W'(1);
         end
         if (hit) begin
            status_in = ssa_pkg::STAT_OK;
            pos_in    = cmp_k_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_avg_in    = rsp_avg_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_data_in   = data_ff;
         rsp_pos_in    = pos_ext[ssa_pkg::POS_W-1:0];
         rsp_count_in  = cnt_ext[ssa_pkg::COUNT_W-1:0];
         rsp_avg_in    = quotient;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         sum_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      k_ff          <= k_in;
      cmp_k_ff      <= cmp_k_in;
      status_ff     <= status_in;
      data_ff       <= data_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_avg_ff    <= rsp_avg_in;
   end

   assign stat.empty     = empty;
   assign stat.srch_done = hit || (!cmp_vld_ff && (k_ff == fill_ff));
   assign stat.div_done  = div_done;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data        = rsp_data_ff;
   assign rsp_match_pos   = rsp_pos_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_average     = rsp_avg_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_COUNT)
      else $error("fill count beyond depth");

   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      empty |-> sum_ff == '0)
      else $error("running sum nonzero on empty stack");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> stat.out_free)
      else $error("response overwritten before it was taken");

endmodule

[design/ssa_ctrl.sv]
// controller state machine sequencing push, pop, search and the average
`timescale 1ns / 1ps

module ssa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [ssa_pkg::TYPE_W-1:0]    req_type,
   output logic                          req_stall,
   input  ssa_pkg::ssa_stat_type         stat,
   output ssa_pkg::ssa_cmd_type          cmd
);

   ssa_pkg::ssa_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ssa_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_type)
                  ssa_pkg::REQ_POP: begin
                     state_in = stat.empty ? ssa_pkg::S_AVG_GO : ssa_pkg::S_POP;
                  end
                  ssa_pkg::REQ_SEARCH: begin
                     state_in = ssa_pkg::S_SEARCH;
                  end
                  default: begin
                     state_in = ssa_pkg::S_AVG_GO;
                  end
               endcase
            end
         end
         ssa_pkg::S_POP: begin
            cmd.pop  = 1'b1;
            state_in = ssa_pkg::S_AVG_GO;
         end
         ssa_pkg::S_SEARCH: begin
            cmd.srch_step = 1'b1;
            if (stat.srch_done) begin
               state_in = ssa_pkg::S_AVG_GO;
            end
         end
         ssa_pkg::S_AVG_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ssa_pkg::S_AVG;
         end
         ssa_pkg::S_AVG: begin
            if (stat.div_done) begin
               state_in = ssa_pkg::S_OUT;
            end
         end
         ssa_pkg::S_OUT: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ssa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ssa_pkg::S_IDLE;
         end
      endcase
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken before the first finished");

   a_div_before_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssa_pkg::S_AVG && stat.div_done) |=> state_ff == ssa_pkg::S_OUT)
      else $error("average finished but no response stage");

endmodule
